// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/lje_pkg.sv =====
`timescale 1ns / 1ps
package lje_pkg;

  localparam int COORD_W = 16;
  localparam int ACC_W   = 32;
  localparam int D_W     = COORD_W + 2;
  localparam int MAG_W   = COORD_W + 1;
  localparam int R2_W    = 2 * COORD_W + 2;
  localparam int NUM_W   = 2 * COORD_W + 18;
  localparam int U_W     = 22;
  localparam int U3_W    = 34;
  localparam int U6_W    = 52;
  localparam int A_W     = 52;
  localparam int AH_W    = 26;
  localparam int G_W     = ACC_W - 1;
  localparam int PB_W    = 80;
  localparam int MA_W    = 36;
  localparam int MB_W    = 24;
  localparam int MP_W    = MA_W + MB_W;
  localparam int FULL_W  = 68;
  localparam int E_W     = 54;
  localparam int CNT_W   = 5;

  localparam logic [COORD_W-1:0] BOX_RESET = 16'd24576;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_SQX, OP_SQY, OP_SQZ, OP_SQS, OP_NUM, OP_ZERO, OP_ULIM,
    OP_LDU, OP_STEP, OP_UU, OP_U3, OP_U6L, OP_U6H, OP_U6, OP_ENER, OP_GML,
    OP_GMH, OP_GNUM, OP_GSCL, OP_GSAT, OP_LDG, OP_GADD, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

  typedef struct packed {
    op_t   op;
    axis_t axis;
  } cmd_t;

  typedef struct packed {
    logic r2_zero;
    logic u_over;
    logic g_over;
    logic mag_zero;
    logic last;
  } sts_t;

  typedef struct packed {
    acc_t val;
    logic sat;
  } sat_res_t;

  function automatic sat_res_t sat_add(acc_t a, acc_t t);
    logic signed [ACC_W:0] s;
    sat_res_t r;
    s = {a[ACC_W-1], a} + {t[ACC_W-1], t};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r.sat = 1'b1;
      r.val = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lje_in_if.sv =====
`timescale 1ns / 1ps
interface lje_in_if;
  logic                        valid;
  logic                        ready;
  logic [lje_pkg::COORD_W-1:0] query_x;
  logic [lje_pkg::COORD_W-1:0] query_y;
  logic [lje_pkg::COORD_W-1:0] query_z;
  logic [lje_pkg::COORD_W-1:0] neighbor_x;
  logic [lje_pkg::COORD_W-1:0] neighbor_y;
  logic [lje_pkg::COORD_W-1:0] neighbor_z;
  logic [lje_pkg::COORD_W-1:0] neighbor_size;
  logic                        last_neighbor;

  modport source (output valid, query_x, query_y, query_z, neighbor_x, neighbor_y,
                  neighbor_z, neighbor_size, last_neighbor, input ready);
  modport sink (input valid, query_x, query_y, query_z, neighbor_x, neighbor_y,
                neighbor_z, neighbor_size, last_neighbor, output ready);
endinterface

// ===== rtl/core/lje_out_if.sv =====
`timescale 1ns / 1ps
interface lje_out_if;
  logic          valid;
  logic          ready;
  lje_pkg::acc_t energy;
  lje_pkg::acc_t grad_x;
  lje_pkg::acc_t grad_y;
  lje_pkg::acc_t grad_z;
  logic          saturated;

  modport source (output valid, energy, grad_x, grad_y, grad_z, saturated, input ready);
  modport sink (input valid, energy, grad_x, grad_y, grad_z, saturated, output ready);
endinterface

// ===== rtl/core/lennard_jones_energy_gradient.sv =====
`timescale 1ns / 1ps
// Flow: a coincident or too-close pair goes from the range check straight to the final
// state; otherwise a 22-step divide for u, then up to three 31-step divides, one per
// non-zero axis offset, run in the shared restoring divider.
// One neighbour is processed at a time: the next transfer is taken on return to idle,
// and a last neighbour holds in the final state while a result still waits.
// Reset: synchronous, active low; clears sums, saturation flag and output valid,
// and sets the box width to 24576.
module lennard_jones_energy_gradient (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lje_pkg::COORD_W-1:0] cfg_data,
  lje_in_if.sink                      in_chan,
  lje_out_if.source                   out_chan
);

  lje_pkg::cmd_t cmd;
  lje_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;

  lje_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lje_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .query_x       (in_chan.query_x),
    .query_y       (in_chan.query_y),
    .query_z       (in_chan.query_z),
    .neighbor_x    (in_chan.neighbor_x),
    .neighbor_y    (in_chan.neighbor_y),
    .neighbor_z    (in_chan.neighbor_z),
    .neighbor_size (in_chan.neighbor_size),
    .last_neighbor (in_chan.last_neighbor),
    .cmd           (cmd),
    .sts           (sts),
    .energy        (out_chan.energy),
    .grad_x        (out_chan.grad_x),
    .grad_y        (out_chan.grad_y),
    .grad_z        (out_chan.grad_z),
    .saturated     (out_chan.saturated)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule

// ===== rtl/core/lje_dp.sv =====
`timescale 1ns / 1ps
module lje_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lje_pkg::COORD_W-1:0] cfg_data,
  input  logic [lje_pkg::COORD_W-1:0] query_x,
  input  logic [lje_pkg::COORD_W-1:0] query_y,
  input  logic [lje_pkg::COORD_W-1:0] query_z,
  input  logic [lje_pkg::COORD_W-1:0] neighbor_x,
  input  logic [lje_pkg::COORD_W-1:0] neighbor_y,
  input  logic [lje_pkg::COORD_W-1:0] neighbor_z,
  input  logic [lje_pkg::COORD_W-1:0] neighbor_size,
  input  logic                        last_neighbor,
  input  lje_pkg::cmd_t               cmd,
  output lje_pkg::sts_t               sts,
  output lje_pkg::acc_t               energy,
  output lje_pkg::acc_t               grad_x,
  output lje_pkg::acc_t               grad_y,
  output lje_pkg::acc_t               grad_z,
  output logic                        saturated
);

  function automatic logic signed [lje_pkg::D_W-1:0] wrap_off(
    logic [lje_pkg::COORD_W-1:0] q,
    logic [lje_pkg::COORD_W-1:0] n,
    logic [lje_pkg::COORD_W-1:0] box,
    logic                        periodic
  );
    logic signed [lje_pkg::D_W-1:0] d;
    logic signed [lje_pkg::D_W-1:0] half;
    logic signed [lje_pkg::D_W-1:0] bw;
    d    = $signed({2'b00, q}) - $signed({2'b00, n});
    half = $signed({3'b000, box[lje_pkg::COORD_W-1:1]});
    bw   = $signed({2'b00, box});
    if (periodic && (d > half)) begin
      d = d - bw;
    end else if (periodic && (d < -half)) begin
      d = d + bw;
    end
    return d;
  endfunction

  function automatic logic [lje_pkg::MAG_W-1:0] mag_of(logic signed [lje_pkg::D_W-1:0] d);
    logic signed [lje_pkg::D_W-1:0] m;
    m = d[lje_pkg::D_W-1] ? -d : d;
    return m[lje_pkg::MAG_W-1:0];
  endfunction

  function automatic lje_pkg::acc_t ulim_term(logic signed [lje_pkg::D_W-1:0] d);
    lje_pkg::acc_t t;
    if (d == '0) begin
      t = '0;
    end else if (d[lje_pkg::D_W-1]) begin
      t = lje_pkg::ACC_MAX;
    end else begin
      t = lje_pkg::ACC_MIN;
    end
    return t;
  endfunction

  logic [lje_pkg::COORD_W-1:0]     box_r;
  logic signed [lje_pkg::D_W-1:0]  dx_r, dy_r, dz_r, d_sel;
  logic [lje_pkg::COORD_W-1:0]     size_r;
  logic                            last_r;
  logic [lje_pkg::MAG_W-1:0]       mag_x, mag_y, mag_z, mag_sel;
  logic [lje_pkg::R2_W-1:0]        r2_r;
  logic [lje_pkg::NUM_W-1:0]       num_r;
  logic [lje_pkg::U_W-1:0]         u_r;
  logic [lje_pkg::U3_W-1:0]        u3_r;
  logic [lje_pkg::MP_W-1:0]        lowp_r, prod_r, prod;
  logic [lje_pkg::U6_W-1:0]        u6_r;
  logic [lje_pkg::FULL_W-1:0]      full;
  logic [lje_pkg::A_W-1:0]         a_r;
  logic                            neg_base_r;
  logic [lje_pkg::PB_W-1:0]        pbig_r;
  logic [lje_pkg::R2_W-1:0]        rem_r;
  logic [lje_pkg::G_W-1:0]         sh_r, quo_r;
  logic [lje_pkg::R2_W:0]          dv_t, dv_diff;
  logic                            dv_ge;
  logic [lje_pkg::MA_W-1:0]        mul_a;
  logic [lje_pkg::MB_W-1:0]        mul_b;
  logic                            mul_en;
  logic signed [lje_pkg::E_W-1:0]  e_term;
  logic                            e_hi, e_lo;
  lje_pkg::acc_t                   e_cl;
  logic                            neg;
  lje_pkg::acc_t                   g_term, gt;
  lje_pkg::acc_t                   e_add, gx_add, gy_add, gz_add;
  logic                            sat_ev;
  lje_pkg::sat_res_t               se, sx, sy, sz;
  lje_pkg::acc_t                   e_sum_r, gx_sum_r, gy_sum_r, gz_sum_r;
  logic                            sat_r;
  lje_pkg::acc_t                   energy_r, grad_x_r, grad_y_r, grad_z_r;
  logic                            out_sat_r;

  assign mag_x = mag_of(dx_r);
  assign mag_y = mag_of(dy_r);
  assign mag_z = mag_of(dz_r);

  always_comb begin
    case (cmd.axis)
      lje_pkg::AX_X: begin
        d_sel   = dx_r;
        mag_sel = mag_x;
      end
      lje_pkg::AX_Y: begin
        d_sel   = dy_r;
        mag_sel = mag_y;
      end
      lje_pkg::AX_Z: begin
        d_sel   = dz_r;
        mag_sel = mag_z;
      end
      default: begin
        d_sel   = dz_r;
        mag_sel = mag_z;
      end
    endcase
  end

  assign sts.r2_zero  = (r2_r == '0);
  assign sts.u_over   = (lje_pkg::R2_W'(num_r[lje_pkg::NUM_W-1:lje_pkg::U_W]) >= r2_r);
  assign sts.g_over   = (pbig_r[lje_pkg::PB_W-1:lje_pkg::G_W] >=
                         (lje_pkg::PB_W-lje_pkg::G_W)'(r2_r));
  assign sts.mag_zero = (mag_sel == '0);
  assign sts.last     = last_r;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      lje_pkg::OP_SQX: begin
        mul_a = lje_pkg::MA_W'(mag_x);
        mul_b = lje_pkg::MB_W'(mag_x);
      end
      lje_pkg::OP_SQY: begin
        mul_a = lje_pkg::MA_W'(mag_y);
        mul_b = lje_pkg::MB_W'(mag_y);
      end
      lje_pkg::OP_SQZ: begin
        mul_a = lje_pkg::MA_W'(mag_z);
        mul_b = lje_pkg::MB_W'(mag_z);
      end
      lje_pkg::OP_SQS: begin
        mul_a = lje_pkg::MA_W'(size_r);
        mul_b = lje_pkg::MB_W'(size_r);
      end
      lje_pkg::OP_UU: begin
        mul_a = lje_pkg::MA_W'(quo_r[lje_pkg::U_W-1:0]);
        mul_b = lje_pkg::MB_W'(quo_r[lje_pkg::U_W-1:0]);
      end
      lje_pkg::OP_U3: begin
        mul_a = lje_pkg::MA_W'(prod_r[2*lje_pkg::U_W-1:16]);
        mul_b = lje_pkg::MB_W'(u_r);
      end
      lje_pkg::OP_U6L: begin
        mul_a = lje_pkg::MA_W'(prod_r[lje_pkg::U3_W+15:16]);
        mul_b = prod_r[lje_pkg::MB_W+15:16];
      end
      lje_pkg::OP_U6H: begin
        mul_a = lje_pkg::MA_W'(u3_r);
        mul_b = lje_pkg::MB_W'(u3_r[lje_pkg::U3_W-1:lje_pkg::MB_W]);
      end
      lje_pkg::OP_GML: begin
        mul_a = lje_pkg::MA_W'(a_r[lje_pkg::AH_W-1:0]);
        mul_b = lje_pkg::MB_W'(mag_sel);
      end
      lje_pkg::OP_GMH: begin
        mul_a = lje_pkg::MA_W'(a_r[lje_pkg::A_W-1:lje_pkg::AH_W]);
        mul_b = lje_pkg::MB_W'(mag_sel);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign prod = lje_pkg::MP_W'(mul_a) * lje_pkg::MP_W'(mul_b);
  assign full = lje_pkg::FULL_W'(lowp_r) + (lje_pkg::FULL_W'(prod_r) << lje_pkg::MB_W);

  assign dv_t    = {rem_r, sh_r[lje_pkg::G_W-1]};
  assign dv_diff = dv_t - {1'b0, r2_r};
  assign dv_ge   = (dv_t >= {1'b0, r2_r});

  assign e_term = $signed(lje_pkg::E_W'(u6_r[lje_pkg::U6_W-1:2])) -
                  $signed(lje_pkg::E_W'(u3_r[lje_pkg::U3_W-1:1]));
  assign e_hi = !e_term[lje_pkg::E_W-1] && (e_term[lje_pkg::E_W-2:lje_pkg::ACC_W-1] != '0);
  assign e_lo = e_term[lje_pkg::E_W-1] && (e_term[lje_pkg::E_W-2:lje_pkg::ACC_W-1] != '1);
  assign e_cl = e_hi ? lje_pkg::ACC_MAX :
                (e_lo ? lje_pkg::ACC_MIN : e_term[lje_pkg::ACC_W-1:0]);

  assign neg    = neg_base_r ^ d_sel[lje_pkg::D_W-1];
  assign g_term = neg ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  always_comb begin
    e_add  = '0;
    gx_add = '0;
    gy_add = '0;
    gz_add = '0;
    gt     = '0;
    sat_ev = 1'b0;
    case (cmd.op)
      lje_pkg::OP_ZERO: begin
        e_add  = lje_pkg::ACC_MAX;
        sat_ev = 1'b1;
      end
      lje_pkg::OP_ULIM: begin
        e_add  = lje_pkg::ACC_MAX;
        gx_add = ulim_term(dx_r);
        gy_add = ulim_term(dy_r);
        gz_add = ulim_term(dz_r);
        sat_ev = 1'b1;
      end
      lje_pkg::OP_ENER: begin
        e_add  = e_cl;
        sat_ev = e_hi | e_lo;
      end
      lje_pkg::OP_GSAT: begin
        gt     = neg ? lje_pkg::ACC_MIN : lje_pkg::ACC_MAX;
        sat_ev = 1'b1;
      end
      lje_pkg::OP_GADD: begin
        gt = g_term;
      end
      default: begin
        sat_ev = 1'b0;
      end
    endcase
    if ((cmd.op == lje_pkg::OP_GSAT) || (cmd.op == lje_pkg::OP_GADD)) begin
      case (cmd.axis)
        lje_pkg::AX_X: gx_add = gt;
        lje_pkg::AX_Y: gy_add = gt;
        lje_pkg::AX_Z: gz_add = gt;
        default:       gz_add = gt;
      endcase
    end
    se = lje_pkg::sat_add(e_sum_r, e_add);
    sx = lje_pkg::sat_add(gx_sum_r, gx_add);
    sy = lje_pkg::sat_add(gy_sum_r, gy_add);
    sz = lje_pkg::sat_add(gz_sum_r, gz_add);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r    <= lje_pkg::BOX_RESET;
      e_sum_r  <= '0;
      gx_sum_r <= '0;
      gy_sum_r <= '0;
      gz_sum_r <= '0;
      sat_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        box_r <= cfg_data;
      end
      if (cmd.op == lje_pkg::OP_EMIT) begin
        e_sum_r  <= '0;
        gx_sum_r <= '0;
        gy_sum_r <= '0;
        gz_sum_r <= '0;
        sat_r    <= 1'b0;
      end else begin
        e_sum_r  <= se.val;
        gx_sum_r <= sx.val;
        gy_sum_r <= sy.val;
        gz_sum_r <= sz.val;
        sat_r    <= sat_r | sat_ev | se.sat | sx.sat | sy.sat | sz.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod;
    end
    case (cmd.op)
      lje_pkg::OP_LOAD: begin
        dx_r   <= wrap_off(query_x, neighbor_x, box_r, 1'b1);
        dy_r   <= wrap_off(query_y, neighbor_y, box_r, 1'b1);
        dz_r   <= wrap_off(query_z, neighbor_z, box_r, 1'b0);
        size_r <= neighbor_size;
        last_r <= last_neighbor;
      end
      lje_pkg::OP_SQY: r2_r <= prod_r[lje_pkg::R2_W-1:0];
      lje_pkg::OP_SQZ: r2_r <= r2_r + prod_r[lje_pkg::R2_W-1:0];
      lje_pkg::OP_SQS: r2_r <= r2_r + prod_r[lje_pkg::R2_W-1:0];
      lje_pkg::OP_NUM: begin
        num_r <= {prod_r[2*lje_pkg::COORD_W-1:0],
                  (lje_pkg::NUM_W-2*lje_pkg::COORD_W)'(0)};
      end
      lje_pkg::OP_LDU: begin
        rem_r <= lje_pkg::R2_W'(num_r[lje_pkg::NUM_W-1:lje_pkg::U_W]);
        sh_r  <= {num_r[lje_pkg::U_W-1:0], (lje_pkg::G_W-lje_pkg::U_W)'(0)};
        quo_r <= '0;
      end
      lje_pkg::OP_LDG: begin
        rem_r <= pbig_r[lje_pkg::G_W+lje_pkg::R2_W-1:lje_pkg::G_W];
        sh_r  <= pbig_r[lje_pkg::G_W-1:0];
        quo_r <= '0;
      end
      lje_pkg::OP_STEP: begin
        rem_r <= dv_ge ? dv_diff[lje_pkg::R2_W-1:0] : dv_t[lje_pkg::R2_W-1:0];
        sh_r  <= sh_r << 1;
        quo_r <= {quo_r[lje_pkg::G_W-2:0], dv_ge};
      end
      lje_pkg::OP_UU:  u_r    <= quo_r[lje_pkg::U_W-1:0];
      lje_pkg::OP_U6L: u3_r   <= prod_r[lje_pkg::U3_W+15:16];
      lje_pkg::OP_U6H: lowp_r <= prod_r;
      lje_pkg::OP_U6:  u6_r   <= full[lje_pkg::U6_W+15:16];
      lje_pkg::OP_ENER: begin
        neg_base_r <= (u6_r > lje_pkg::A_W'(u3_r));
        a_r        <= (u6_r > lje_pkg::A_W'(u3_r)) ? (u6_r - lje_pkg::A_W'(u3_r))
                                                   : (lje_pkg::A_W'(u3_r) - u6_r);
      end
      lje_pkg::OP_GMH:  pbig_r <= lje_pkg::PB_W'(prod_r);
      lje_pkg::OP_GNUM: pbig_r <= pbig_r + (lje_pkg::PB_W'(prod_r) << lje_pkg::AH_W);
      lje_pkg::OP_GSCL: pbig_r <= (pbig_r << 9) + (pbig_r << 8);
      lje_pkg::OP_EMIT: begin
        energy_r  <= e_sum_r;
        grad_x_r  <= gx_sum_r;
        grad_y_r  <= gy_sum_r;
        grad_z_r  <= gz_sum_r;
        out_sat_r <= sat_r;
      end
      default: begin
        last_r <= last_r;
      end
    endcase
  end

  assign energy    = energy_r;
  assign grad_x    = grad_x_r;
  assign grad_y    = grad_y_r;
  assign grad_z    = grad_z_r;
  assign saturated = out_sat_r;

endmodule

// ===== rtl/core/lje_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lje_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lje_pkg::sts_t  sts,
  output lje_pkg::cmd_t  cmd
);

  typedef enum logic [21:0] {
    S_IDLE = 22'h000001,
    S_SQX  = 22'h000002,
    S_SQY  = 22'h000004,
    S_SQZ  = 22'h000008,
    S_SQS  = 22'h000010,
    S_NUM  = 22'h000020,
    S_CHK  = 22'h000040,
    S_DIVU = 22'h000080,
    S_UU   = 22'h000100,
    S_U3   = 22'h000200,
    S_U6L  = 22'h000400,
    S_U6H  = 22'h000800,
    S_U6   = 22'h001000,
    S_ENER = 22'h002000,
    S_GML  = 22'h004000,
    S_GMH  = 22'h008000,
    S_GNUM = 22'h010000,
    S_GSCL = 22'h020000,
    S_GCHK = 22'h040000,
    S_GDIV = 22'h080000,
    S_GADD = 22'h100000,
    S_FIN  = 22'h200000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [lje_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  lje_pkg::axis_t               axis_r, axis_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = lje_pkg::OP_NOP;
    cmd.axis      = axis_r;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = lje_pkg::OP_LOAD;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.op    = lje_pkg::OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = lje_pkg::OP_SQY;
        state_nxt = S_SQZ;
      end
      S_SQZ: begin
        cmd.op    = lje_pkg::OP_SQZ;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        cmd.op    = lje_pkg::OP_SQS;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.op    = lje_pkg::OP_NUM;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.r2_zero) begin
          cmd.op    = lje_pkg::OP_ZERO;
          state_nxt = S_FIN;
        end else if (sts.u_over) begin
          cmd.op    = lje_pkg::OP_ULIM;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = lje_pkg::OP_LDU;
          cnt_nxt   = '0;
          state_nxt = S_DIVU;
        end
      end
      S_DIVU: begin
        cmd.op  = lje_pkg::OP_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == lje_pkg::CNT_W'(lje_pkg::U_W - 1)) begin
          state_nxt = S_UU;
        end
      end
      S_UU: begin
        cmd.op    = lje_pkg::OP_UU;
        state_nxt = S_U3;
      end
      S_U3: begin
        cmd.op    = lje_pkg::OP_U3;
        state_nxt = S_U6L;
      end
      S_U6L: begin
        cmd.op    = lje_pkg::OP_U6L;
        state_nxt = S_U6H;
      end
      S_U6H: begin
        cmd.op    = lje_pkg::OP_U6H;
        state_nxt = S_U6;
      end
      S_U6: begin
        cmd.op    = lje_pkg::OP_U6;
        state_nxt = S_ENER;
      end
      S_ENER: begin
        cmd.op    = lje_pkg::OP_ENER;
        axis_nxt  = lje_pkg::AX_X;
        state_nxt = S_GML;
      end
      S_GML: begin
        if (sts.mag_zero) begin
          if (axis_r == lje_pkg::AX_Z) begin
            state_nxt = S_FIN;
          end else begin
            axis_nxt = lje_pkg::axis_t'(axis_r + 2'd1);
          end
        end else begin
          cmd.op    = lje_pkg::OP_GML;
          state_nxt = S_GMH;
        end
      end
      S_GMH: begin
        cmd.op    = lje_pkg::OP_GMH;
        state_nxt = S_GNUM;
      end
      S_GNUM: begin
        cmd.op    = lje_pkg::OP_GNUM;
        state_nxt = S_GSCL;
      end
      S_GSCL: begin
        cmd.op    = lje_pkg::OP_GSCL;
        state_nxt = S_GCHK;
      end
      S_GCHK: begin
        if (sts.g_over) begin
          cmd.op = lje_pkg::OP_GSAT;
          if (axis_r == lje_pkg::AX_Z) begin
            state_nxt = S_FIN;
          end else begin
            axis_nxt  = lje_pkg::axis_t'(axis_r + 2'd1);
            state_nxt = S_GML;
          end
        end else begin
          cmd.op    = lje_pkg::OP_LDG;
          cnt_nxt   = '0;
          state_nxt = S_GDIV;
        end
      end
      S_GDIV: begin
        cmd.op  = lje_pkg::OP_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == lje_pkg::CNT_W'(lje_pkg::G_W - 1)) begin
          state_nxt = S_GADD;
        end
      end
      S_GADD: begin
        cmd.op = lje_pkg::OP_GADD;
        if (axis_r == lje_pkg::AX_Z) begin
          state_nxt = S_FIN;
        end else begin
          axis_nxt  = lje_pkg::axis_t'(axis_r + 2'd1);
          state_nxt = S_GML;
        end
      end
      S_FIN: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.op        = lje_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      axis_r      <= lje_pkg::AX_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_PROP(a_accept_starts, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_SQX))
  `ASSERT_PROP(a_div_bound, clk, rst_n, (state_r == S_DIVU) |-> (cnt_r < lje_pkg::CNT_W'(lje_pkg::U_W)))
  `ASSERT_PROP(a_emit_from_fin, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_FIN))
  `ASSERT_NEVER(a_emit_needs_last, clk, rst_n, (cmd.op == lje_pkg::OP_EMIT) && !sts.last)

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [15:0] qx, qy, qz, nx, ny, nz, size;
    logic        last;
  } pair_t;

  typedef struct {
    lje_pkg::acc_t energy, gx, gy, gz;
    logic sat;
  } lj_sums_t;

  localparam longint LJ_MAX = 64'sd2147483647;
  localparam longint LJ_MIN = -64'sd2147483648;
  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  lje_in_if  in_chan();
  lje_out_if out_chan();

  lennard_jones_energy_gradient dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_chan(in_chan), .out_chan(out_chan)
  );

  longint unsigned box_q;
  longint e_acc, gx_acc, gy_acc, gz_acc;
  logic sat_seen;
  lj_sums_t sums_due[$];

  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  bit hold_go = 0;
  bit hold_active = 0;
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    out_chan.ready <= !hold_active && ($urandom_range(99) >= stall_pct);
  end

  function automatic longint clamp_sum(longint v);
    if (v > LJ_MAX) begin sat_seen = 1; return LJ_MAX; end
    if (v < LJ_MIN) begin sat_seen = 1; return LJ_MIN; end
    return v;
  endfunction

  function automatic longint add_clamped(longint acc, longint t);
    longint tc;
    tc = clamp_sum(t);
    if (tc > 0 && acc > LJ_MAX - tc) begin sat_seen = 1; return LJ_MAX; end
    if (tc < 0 && acc < LJ_MIN - tc) begin sat_seen = 1; return LJ_MIN; end
    return acc + tc;
  endfunction

  function automatic longint min_image(longint unsigned q, longint unsigned n, bit wrap);
    longint d, bw, half;
    bw = longint'(box_q);
    half = longint'(box_q >> 1);
    d = longint'(q) - longint'(n);
    if (wrap) begin
      if (d > half) d = d - bw;
      else if (d < -half) d = d + bw;
    end
    return d;
  endfunction

  function automatic longint unsigned q16_mul(longint unsigned a, longint unsigned b);
    return (a >> 16) * b + (((a & 64'hFFFF) * b) >> 16);
  endfunction

  function automatic longint axis_force(longint unsigned m, longint unsigned r2, longint d,
                                        bit neg_base);
    longint unsigned mag, q1, r1, g, lim;
    bit neg;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    lim = 64'd2147483647;
    neg = neg_base != (d < 0);
    if (mag == 0) return 0;
    q1 = m / r2;
    r1 = m % r2;
    if (q1 > lim / mag) begin sat_seen = 1; return neg ? LJ_MIN : LJ_MAX; end
    g = q1 * mag + (r1 * mag) / r2;
    if (g > lim) begin sat_seen = 1; return neg ? LJ_MIN : LJ_MAX; end
    return neg ? -longint'(g) : longint'(g);
  endfunction

  function automatic longint pin_sign(longint d);
    if (d == 0) return 0;
    return (d > 0) ? LJ_MIN : LJ_MAX;
  endfunction

  task automatic accumulate_pair(pair_t p);
    longint dx, dy, dz;
    longint unsigned sz, r2, u, u2, u3, u6, a, m;
    bit nb;
    lj_sums_t s;
    dx = min_image(p.qx, p.nx, 1);
    dy = min_image(p.qy, p.ny, 1);
    dz = min_image(p.qz, p.nz, 0);
    sz = 64'(p.size);
    r2 = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    if (r2 == 0) begin
      sat_seen = 1;
      e_acc = add_clamped(e_acc, LJ_MAX);
    end else begin
      u = ((sz * sz * 4) << 16) / r2;
      if (u >= (64'd64 << 16)) begin
        sat_seen = 1;
        e_acc = add_clamped(e_acc, LJ_MAX);
        gx_acc = add_clamped(gx_acc, pin_sign(dx));
        gy_acc = add_clamped(gy_acc, pin_sign(dy));
        gz_acc = add_clamped(gz_acc, pin_sign(dz));
      end else begin
        u2 = q16_mul(u, u);
        u3 = q16_mul(u2, u);
        u6 = q16_mul(u3, u3);
        nb = u6 > u3;
        a = nb ? u6 - u3 : u3 - u6;
        m = a * 768;
        e_acc = add_clamped(e_acc, longint'(u6 >> 2) - longint'(u3 >> 1));
        gx_acc = add_clamped(gx_acc, axis_force(m, r2, dx, nb));
        gy_acc = add_clamped(gy_acc, axis_force(m, r2, dy, nb));
        gz_acc = add_clamped(gz_acc, axis_force(m, r2, dz, nb));
      end
    end
    if (p.last) begin
      s.energy = lje_pkg::acc_t'(e_acc);
      s.gx = lje_pkg::acc_t'(gx_acc);
      s.gy = lje_pkg::acc_t'(gy_acc);
      s.gz = lje_pkg::acc_t'(gz_acc);
      s.sat = sat_seen;
      sums_due = {sums_due, s};
      e_acc = 0; gx_acc = 0; gy_acc = 0; gz_acc = 0;
      sat_seen = 0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
  endtask

  initial begin
    lj_sums_t w;
    forever begin
      @(negedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (sums_due.size() == 0) begin
          report_mismatch("unexpected result", out_chan.energy, 0);
        end else begin
          w = sums_due.pop_front();
          if (out_chan.energy !== w.energy) report_mismatch("energy", out_chan.energy, w.energy);
          if (out_chan.grad_x !== w.gx) report_mismatch("grad_x", out_chan.grad_x, w.gx);
          if (out_chan.grad_y !== w.gy) report_mismatch("grad_y", out_chan.grad_y, w.gy);
          if (out_chan.grad_z !== w.gz) report_mismatch("grad_z", out_chan.grad_z, w.gz);
          if (out_chan.saturated !== w.sat)
            report_mismatch("saturated", out_chan.saturated, w.sat);
        end
      end
    end
  end

  task automatic send_pair(pair_t p);
    bit took;
    while ($urandom_range(99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.query_x <= p.qx; in_chan.query_y <= p.qy; in_chan.query_z <= p.qz;
    in_chan.neighbor_x <= p.nx; in_chan.neighbor_y <= p.ny; in_chan.neighbor_z <= p.nz;
    in_chan.neighbor_size <= p.size; in_chan.last_neighbor <= p.last;
    do begin
      @(negedge clk);
      took = in_chan.ready;
      @(posedge clk);
    end while (!took);
    accumulate_pair(p);
  endtask

  task automatic drain;
    in_chan.valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_box(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    box_q = 64'(v);
  endtask

  function automatic pair_t mk(int qx, int qy, int qz, int nx, int ny, int nz, int sz,
                               bit last);
    pair_t p;
    p.qx = 16'(qx); p.qy = 16'(qy); p.qz = 16'(qz);
    p.nx = 16'(nx); p.ny = 16'(ny); p.nz = 16'(nz);
    p.size = 16'(sz); p.last = last;
    return p;
  endfunction

  function automatic pair_t rand_pair(bit last);
    pair_t p;
    int span;
    if ($urandom_range(99) < 20) begin
      p.qx = 16'($urandom); p.qy = 16'($urandom); p.qz = 16'($urandom);
      p.nx = 16'($urandom); p.ny = 16'($urandom); p.nz = 16'($urandom);
      p.size = 16'($urandom);
    end else begin
      span = ($urandom_range(3) == 0) ? 4096 : 1024;
      p.qx = 16'($urandom); p.qy = 16'($urandom); p.qz = 16'($urandom);
      p.nx = 16'(p.qx + $urandom_range(2 * span) - span);
      p.ny = 16'(p.qy + $urandom_range(2 * span) - span);
      p.nz = 16'(p.qz + $urandom_range(2 * span) - span);
      p.size = 16'($urandom_range(384));
    end
    p.last = last;
    return p;
  endfunction

  task automatic run_queries(int n);
    int k, j;
    for (k = 0; k < n; k++) begin
      j = $urandom_range(5);
      repeat (j) send_pair(rand_pair(1'b0));
      send_pair(rand_pair(1'b1));
    end
  endtask

  task automatic test_directed;
    gap_pct = 0; stall_pct = 0;
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 1));
    send_pair(mk(100, 200, 300, 100, 200, 300, 65535, 1));
    send_pair(mk(65535, 65535, 65535, 65535, 65535, 65535, 65535, 1));
    send_pair(mk(65535, 65535, 65535, 0, 0, 0, 65535, 1));
    send_pair(mk(0, 0, 0, 65535, 65535, 65535, 0, 1));
    send_pair(mk(1000, 1000, 1000, 1001, 1000, 1000, 256, 1));
    send_pair(mk(1000, 1000, 1000, 1000, 1000, 1256, 256, 0));
    send_pair(mk(1000, 1000, 1000, 1512, 1000, 1000, 256, 0));
    send_pair(mk(1000, 1000, 1000, 1000, 700, 900, 128, 1));
    send_pair(mk(12288, 0, 0, 0, 0, 0, 100, 1));
    send_pair(mk(0, 12288, 0, 0, 0, 0, 100, 1));
    send_pair(mk(12289, 0, 0, 0, 12289, 0, 100, 1));
    send_pair(mk(24000, 100, 50, 200, 24000, 50, 200, 1));
    send_pair(mk(500, 500, 500, 600, 400, 500, 65535, 1));
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk(300, 300, 300, 300, 300, 300, 0, 1));
    set_box(16'd256);
    send_pair(mk(0, 0, 0, 200, 60, 0, 64, 1));
    send_pair(mk(65535, 1, 0, 0, 65535, 0, 64, 1));
    set_box(16'd65535);
    send_pair(mk(0, 65535, 7, 65535, 0, 7, 64, 1));
    send_pair(mk(32767, 0, 0, 0, 32768, 0, 200, 1));
  endtask

  task automatic test_no_idle;
    set_box(16'd24576);
    gap_pct = 0; stall_pct = 0;
    run_queries(100);
  endtask

  task automatic test_sender_idle;
    set_box(16'd256);
    gap_pct = 73; stall_pct = 0;
    run_queries(75);
  endtask

  task automatic test_receiver_stall;
    set_box(16'd65535);
    gap_pct = 0; stall_pct = 73;
    run_queries(75);
  endtask

  task automatic test_both_idle;
    set_box(16'($urandom_range(65535, 256)));
    gap_pct = 6; stall_pct = 6;
    run_queries(75);
  endtask

  task automatic test_held_output;
    set_box(16'($urandom_range(4096, 256)));
    gap_pct = 0; stall_pct = 0;
    hold_go = 1;
    repeat (20) send_pair(rand_pair(1'b1));
    run_queries(40);
  endtask

  task automatic test_pause_to_empty;
    int k;
    set_box(16'd24576);
    gap_pct = 20; stall_pct = 30;
    for (k = 0; k < 8; k++) begin
      run_queries(6);
      in_chan.valid <= 1'b0;
      while (sums_due.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    in_chan.valid <= 1'b0;
    in_chan.query_x <= '0; in_chan.query_y <= '0; in_chan.query_z <= '0;
    in_chan.neighbor_x <= '0; in_chan.neighbor_y <= '0; in_chan.neighbor_z <= '0;
    in_chan.neighbor_size <= '0; in_chan.last_neighbor <= 1'b0;
    box_q = 24576;
    e_acc = 0; gx_acc = 0; gy_acc = 0; gz_acc = 0;
    sat_seen = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_held_output();
    test_pause_to_empty();
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lje_pkg.sv
rtl/core/lje_in_if.sv
rtl/core/lje_out_if.sv
rtl/core/lje_dp.sv
rtl/core/lje_ctrl.sv
rtl/core/lennard_jones_energy_gradient.sv
verif/tb.sv
